// ===== design/lvc_pkg.sv =====
// Shared types, constants and arithmetic helpers for the lookahead velocity controller.
// Used by lvc_csr, lvc_ctrl, lvc_datapath and the top level; no dependencies.
package lvc_pkg;

   localparam int ANG_PI      = 205887;
   localparam int ANG_2PI     = 411775;
   localparam int ANG_HALF_PI = 102944;
   localparam int INV_GAIN    = 163008218;
   localparam int TH_BIG      = 98304;
   localparam int TH_MID      = 32768;
   localparam int SLOW_BIG    = 655;
   localparam int SLOW_MID    = 1966;
   localparam int CORDIC_STEPS = 17;
   localparam int MUL_OPS     = 10;

   localparam int STEP_W = 5;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_MAX_FWD   = 3'd0,
      CSR_MAX_TURN  = 3'd1,
      CSR_ACC_FWD   = 3'd2,
      CSR_ACC_SIDE  = 3'd3,
      CSR_ACC_TURN  = 3'd4,
      CSR_STOP_RNG  = 3'd5,
      CSR_ARRIVE    = 3'd6
   } csr_idx_type;

   // multiplier operations, issued in this order
   typedef enum logic [3:0] {
      OP_DX_LO    = 4'd0,
      OP_DX_HI    = 4'd1,
      OP_DY_LO    = 4'd2,
      OP_DY_HI    = 4'd3,
      OP_DX_SQ    = 4'd4,
      OP_DY_SQ    = 4'd5,
      OP_R_SQ     = 4'd6,
      OP_LIM_FWD  = 4'd7,
      OP_LIM_SIDE = 4'd8,
      OP_LIM_TURN = 4'd9
   } mul_op_type;

   typedef struct packed {
      logic [22:0] max_fwd;
      logic [22:0] max_turn;
      logic [23:0] acc_fwd;
      logic [23:0] acc_side;
      logic [23:0] acc_turn;
      logic [23:0] stop_range;
      logic [23:0] arrive;
   } cfg_type;

   typedef struct packed {
      logic              latch;
      logic              init;
      logic              rotate;
      logic              mul;
      logic              decide;
      logic              finish;
      logic [STEP_W-1:0] step;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic logic [16:0] atan_lut(logic [STEP_W-1:0] idx);
      logic [16:0] r;
      case (idx)
         5'd0:    r = 17'd51472;
         5'd1:    r = 17'd30386;
         5'd2:    r = 17'd16055;
         5'd3:    r = 17'd8150;
         5'd4:    r = 17'd4091;
         5'd5:    r = 17'd2047;
         5'd6:    r = 17'd1024;
         5'd7:    r = 17'd512;
         5'd8:    r = 17'd256;
         5'd9:    r = 17'd128;
         5'd10:   r = 17'd64;
         5'd11:   r = 17'd32;
         5'd12:   r = 17'd16;
         5'd13:   r = 17'd8;
         5'd14:   r = 17'd4;
         5'd15:   r = 17'd2;
         5'd16:   r = 17'd1;
         default: r = 17'd0;
      endcase
      return r;
   endfunction

   // step toward v by at most lim/65536 from last
   function automatic logic signed [37:0] rate_limit(logic signed [35:0] v,
                                                     logic signed [23:0] last,
                                                     logic [47:0] lim);
      logic signed [37:0] d;
      logic [37:0]        ad;
      logic signed [37:0] stp;
      d   = 38'(v) - 38'(last);
      ad  = d[37] ? 38'(-d) : 38'(d);
      stp = $signed({6'b0, lim[47:16]});
      if ({ad, 16'b0} > {6'b0, lim}) begin
         return (d > 0) ? 38'(last) + stp : 38'(last) - stp;
      end
      return 38'(v);
   endfunction

   function automatic logic signed [23:0] sat24(logic signed [37:0] v);
      if (v > 38'sd8388607) begin
         return 24'sh7FFFFF;
      end
      if (v < -38'sd8388608) begin
         return 24'sh800000;
      end
      return v[23:0];
   endfunction

endpackage

// ===== design/lvc_csr.sv =====
// Configuration register bank of the lookahead velocity controller.
// Depends on lvc_pkg for the register indexes and the cfg_type bundle.
module lvc_csr import lvc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_FWD:  cfg_in.max_fwd    = csr_wdata[22:0];
            CSR_MAX_TURN: cfg_in.max_turn   = csr_wdata[22:0];
            CSR_ACC_FWD:  cfg_in.acc_fwd    = csr_wdata;
            CSR_ACC_SIDE: cfg_in.acc_side   = csr_wdata;
            CSR_ACC_TURN: cfg_in.acc_turn   = csr_wdata;
            CSR_STOP_RNG: cfg_in.stop_range = csr_wdata;
            CSR_ARRIVE:   cfg_in.arrive     = csr_wdata;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fwd    <= 23'd13107;
         cfg_ff.max_turn   <= 23'd19661;
         cfg_ff.acc_fwd    <= 24'd327680;
         cfg_ff.acc_side   <= 24'd65536;
         cfg_ff.acc_turn   <= 24'd327680;
         cfg_ff.stop_range <= 24'd45875;
         cfg_ff.arrive     <= 24'd6554;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== design/lvc_ctrl.sv =====
// Sequencer of the lookahead velocity controller: steps the datapath through
// load, CORDIC, multiply, decide and limit phases. Depends on lvc_pkg.
module lvc_ctrl import lvc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOAD   = 6'b000010,
      S_ROT    = 6'b000100,
      S_MUL    = 6'b001000,
      S_DECIDE = 6'b010000,
      S_LIMIT  = 6'b100000
   } ctrl_state_type;

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            state_in = S_ROT;
            step_in  = '0;
         end
         S_ROT: begin
            if (step_ff == STEP_W'(CORDIC_STEPS - 1)) begin
               state_in = S_MUL;
               step_in  = '0;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MUL: begin
            // one extra step drains the last product
            if (step_ff == STEP_W'(MUL_OPS)) begin
               state_in = S_DECIDE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_DECIDE: state_in = S_LIMIT;
         S_LIMIT: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd.latch  = (state_ff == S_IDLE) && req_valid;
      cmd.init   = (state_ff == S_LOAD);
      cmd.rotate = (state_ff == S_ROT);
      cmd.mul    = (state_ff == S_MUL);
      cmd.decide = (state_ff == S_DECIDE);
      cmd.finish = (state_ff == S_LIMIT) && status.out_free;
      cmd.step   = step_ff;
   end

`ifndef NO_ASSERTIONS
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == S_LOAD && req_stall)
      else $error("accepted request did not start the load phase");
   a_rot_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROT |-> step_ff <= STEP_W'(CORDIC_STEPS - 1))
      else $error("CORDIC step counter overran");
   a_mul_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |-> step_ff <= STEP_W'(MUL_OPS))
      else $error("multiply step counter overran");
   a_finish_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> state_ff == S_IDLE && !req_stall)
      else $error("finished request did not return to idle");
`endif

endmodule

// ===== design/lvc_datapath.sv =====
// Datapath of the lookahead velocity controller: two CORDIC units, one shared
// multiplier, decision logic, rate limiters and the response register. Uses lvc_pkg.
module lvc_datapath import lvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  cfg_type            cfg,
   input  logic signed [31:0] req_robot_x,
   input  logic signed [31:0] req_robot_y,
   input  logic signed [19:0] req_robot_heading,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [19:0] req_target_heading,
   input  logic               req_is_final,
   input  logic [23:0]        req_elapsed_time,
   input  logic               req_obstacle_seen,
   input  logic [23:0]        req_obstacle_range,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_fwd_velocity,
   output logic signed [23:0] rsp_side_velocity,
   output logic signed [23:0] rsp_turn_rate
);

   localparam logic signed [20:0] A_PI    = 21'(ANG_PI);
   localparam logic signed [20:0] A_2PI   = 21'(ANG_2PI);
   localparam logic signed [20:0] A_HALF  = 21'(ANG_HALF_PI);
   localparam logic signed [21:0] E_PI    = 22'(ANG_PI);
   localparam logic signed [21:0] E_2PI   = 22'(ANG_2PI);

   // latched request
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [19:0] rh_ff, th_ff;
   logic               fin_ff, obs_ff;
   logic [23:0]        dt_ff, orng_ff;

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         dx_ff   <= 33'(req_target_x) - 33'(req_robot_x);
         dy_ff   <= 33'(req_target_y) - 33'(req_robot_y);
         rh_ff   <= req_robot_heading;
         th_ff   <= req_target_heading;
         fin_ff  <= req_is_final;
         dt_ff   <= req_elapsed_time;
         obs_ff  <= req_obstacle_seen;
         orng_ff <= req_obstacle_range;
      end
   end

   // rotation CORDIC (sin/cos of heading, Q28)
   logic signed [31:0] rx_ff, rx_in, ry_ff, ry_in;
   logic signed [20:0] rz_ff, rz_in;
   logic               neg_ff, neg_in;
   // vectoring CORDIC (bearing of the offset)
   logic signed [59:0] vx_ff, vx_in, vy_ff, vy_in;
   logic signed [20:0] vz_ff, vz_in;
   logic               zero_ff, zero_in;

   logic signed [20:0] h0, hw, at;
   logic signed [59:0] dxe, dye;

   always_comb begin
      rx_in = rx_ff; ry_in = ry_ff; rz_in = rz_ff; neg_in = neg_ff;
      vx_in = vx_ff; vy_in = vy_ff; vz_in = vz_ff; zero_in = zero_ff;
      h0  = 21'(rh_ff);
      hw  = h0;
      dxe = {{3{dx_ff[32]}}, dx_ff, 24'b0};
      dye = {{3{dy_ff[32]}}, dy_ff, 24'b0};
      at  = $signed({4'b0, atan_lut(cmd.step)});
      if (cmd.init) begin
         // wrap heading once into +/- pi, fold into +/- pi/2
         if (h0 > A_PI) begin
            hw = h0 - A_2PI;
         end else if (h0 < -A_PI) begin
            hw = h0 + A_2PI;
         end
         rx_in  = 32'(INV_GAIN);
         ry_in  = '0;
         neg_in = 1'b0;
         rz_in  = hw;
         if (hw > A_HALF) begin
            rz_in  = hw - A_PI;
            neg_in = 1'b1;
         end else if (hw < -A_HALF) begin
            rz_in  = hw + A_PI;
            neg_in = 1'b1;
         end
         zero_in = (dx_ff == '0) && (dy_ff == '0);
         vz_in   = '0;
         vx_in   = dxe;
         vy_in   = dye;
         if (dx_ff[32]) begin
            vz_in = dy_ff[32] ? -A_PI : A_PI;
            vx_in = -dxe;
            vy_in = -dye;
         end
      end else if (cmd.rotate) begin
         if (rz_ff >= 0) begin
            rx_in = rx_ff - (ry_ff >>> cmd.step);
            ry_in = ry_ff + (rx_ff >>> cmd.step);
            rz_in = rz_ff - at;
         end else begin
            rx_in = rx_ff + (ry_ff >>> cmd.step);
            ry_in = ry_ff - (rx_ff >>> cmd.step);
            rz_in = rz_ff + at;
         end
         if (vy_ff < 0) begin
            vx_in = vx_ff - (vy_ff >>> cmd.step);
            vy_in = vy_ff + (vx_ff >>> cmd.step);
            vz_in = vz_ff - at;
         end else begin
            vx_in = vx_ff + (vy_ff >>> cmd.step);
            vy_in = vy_ff - (vx_ff >>> cmd.step);
            vz_in = vz_ff + at;
         end
      end
   end

   always_ff @(posedge clock) begin
      rx_ff <= rx_in; ry_ff <= ry_in; rz_ff <= rz_in; neg_ff <= neg_in;
      vx_ff <= vx_in; vy_ff <= vy_in; vz_ff <= vz_in; zero_ff <= zero_in;
   end

   // shared multiplier
   logic signed [31:0] cosv, sinv;
   logic [32:0]        adx, ady;
   logic signed [24:0] mul_a;
   logic signed [31:0] mul_b;
   logic signed [56:0] prod_ff;
   mul_op_type         op, op_q_ff;
   logic               pvld_ff;

   assign cosv = neg_ff ? -rx_ff : rx_ff;
   assign sinv = neg_ff ? -ry_ff : ry_ff;
   assign adx  = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ady  = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign op   = mul_op_type'(cmd.step[3:0]);

   always_comb begin
      case (op)
         OP_DX_LO: begin
            mul_a = $signed({9'b0, dx_ff[15:0]});
            mul_b = cosv;
         end
         OP_DX_HI: begin
            mul_a = $signed({{8{dx_ff[32]}}, dx_ff[32:16]});
            mul_b = cosv;
         end
         OP_DY_LO: begin
            mul_a = $signed({9'b0, dy_ff[15:0]});
            mul_b = sinv;
         end
         OP_DY_HI: begin
            mul_a = $signed({{8{dy_ff[32]}}, dy_ff[32:16]});
            mul_b = sinv;
         end
         OP_DX_SQ: begin
            mul_a = $signed({1'b0, adx[23:0]});
            mul_b = $signed({8'b0, adx[23:0]});
         end
         OP_DY_SQ: begin
            mul_a = $signed({1'b0, ady[23:0]});
            mul_b = $signed({8'b0, ady[23:0]});
         end
         OP_R_SQ: begin
            mul_a = $signed({1'b0, cfg.arrive});
            mul_b = $signed({8'b0, cfg.arrive});
         end
         OP_LIM_FWD: begin
            mul_a = $signed({1'b0, cfg.acc_fwd});
            mul_b = $signed({8'b0, dt_ff});
         end
         OP_LIM_SIDE: begin
            mul_a = $signed({1'b0, cfg.acc_side});
            mul_b = $signed({8'b0, dt_ff});
         end
         OP_LIM_TURN: begin
            mul_a = $signed({1'b0, cfg.acc_turn});
            mul_b = $signed({8'b0, dt_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff <= 1'b0;
      end else begin
         pvld_ff <= cmd.mul && (cmd.step < STEP_W'(MUL_OPS));
      end
      prod_ff <= mul_a * mul_b;
      op_q_ff <= op;
   end

   // product collection
   logic signed [63:0] exacc_ff;
   logic [47:0]        sqx_ff, sqy_ff, r2_ff, lf_ff, ls_ff, lt_ff;

   always_ff @(posedge clock) begin
      if (cmd.init) begin
         exacc_ff <= 64'sd134217728;
      end else if (pvld_ff) begin
         case (op_q_ff)
            OP_DX_LO, OP_DY_LO: exacc_ff <= exacc_ff + 64'(prod_ff);
            OP_DX_HI, OP_DY_HI: exacc_ff <= exacc_ff + (64'(prod_ff) <<< 16);
            OP_DX_SQ:    sqx_ff <= prod_ff[47:0];
            OP_DY_SQ:    sqy_ff <= prod_ff[47:0];
            OP_R_SQ:     r2_ff  <= prod_ff[47:0];
            OP_LIM_FWD:  lf_ff  <= prod_ff[47:0];
            OP_LIM_SIDE: ls_ff  <= prod_ff[47:0];
            OP_LIM_TURN: lt_ff  <= prod_ff[47:0];
            default:     exacc_ff <= exacc_ff;
         endcase
      end
   end

   // decision
   logic signed [35:0] ex, vxd_in, vad_in, vxd_ff, vad_ff, mfs, amax;
   logic [35:0]        aex;
   logic signed [21:0] ea0, ea;
   logic [21:0]        aea;
   logic               near;

   always_comb begin
      ex   = exacc_ff[63:28];
      aex  = ex[35] ? 36'(-ex) : 36'(ex);
      ea0  = 22'(zero_ff ? 21'sd0 : vz_ff) - 22'(rh_ff);
      ea   = ea0;
      if (ea0 < -E_PI) begin
         ea = ea0 + E_2PI;
      end else if (ea0 > E_PI) begin
         ea = ea0 - E_2PI;
      end
      aea  = ea[21] ? 22'(-ea) : 22'(ea);
      near = (adx[32:24] == '0) && (ady[32:24] == '0) &&
             (({1'b0, sqx_ff} + {1'b0, sqy_ff}) < {1'b0, r2_ff});
      mfs  = $signed({13'b0, cfg.max_fwd});
      amax = $signed({13'b0, cfg.max_turn});
      vxd_in = near ? ex : mfs;
      if (vxd_in > mfs) begin
         vxd_in = mfs;
      end
      vad_in = 36'(ea);
      if (vad_in > amax) begin
         vad_in = amax;
      end else if (vad_in < -amax) begin
         vad_in = -amax;
      end
      // slow down at large bearing error
      if (aea > 22'(TH_BIG)) begin
         if (aex > 36'(SLOW_BIG)) begin
            vxd_in = 36'(SLOW_BIG);
         end
      end else if (aea > 22'(TH_MID)) begin
         if (aex > 36'(SLOW_MID)) begin
            vxd_in = 36'(SLOW_MID);
         end
      end
      // final point reached: stop and turn toward the target heading
      if (fin_ff && near) begin
         vxd_in = '0;
         vad_in = 36'(th_ff) - 36'(rh_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         vxd_ff <= vxd_in;
         vad_ff <= vad_in;
      end
   end

   // rate limit, obstacle stop, response register
   logic signed [23:0] last_fwd_ff, last_side_ff, last_turn_ff;
   logic signed [23:0] nf, ns, nt;
   logic               stop;
   logic               rsp_valid_ff;
   logic signed [23:0] rsp_fwd_ff, rsp_side_ff, rsp_turn_ff;

   always_comb begin
      stop = obs_ff && (orng_ff <= cfg.stop_range);
      nf   = stop ? 24'sd0 : sat24(rate_limit(vxd_ff, last_fwd_ff, lf_ff));
      ns   = stop ? 24'sd0 : sat24(rate_limit(36'sd0, last_side_ff, ls_ff));
      nt   = stop ? 24'sd0 : sat24(rate_limit(vad_ff, last_turn_ff, lt_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_fwd_ff  <= '0;
         last_side_ff <= '0;
         last_turn_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         last_fwd_ff  <= nf;
         last_side_ff <= ns;
         last_turn_ff <= nt;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_fwd_ff  <= nf;
         rsp_side_ff <= ns;
         rsp_turn_ff <= nt;
      end
   end

   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fwd_velocity  = rsp_fwd_ff;
   assign rsp_side_velocity = rsp_side_ff;
   assign rsp_turn_rate     = rsp_turn_ff;

endmodule

// ===== design/lookahead_velocity_controller.sv =====
// Lookahead velocity controller: one request at a time; req_stall stays high from accept
// until the response is registered, a span set by the 17-step CORDIC loop and the
// ten operations on the single shared multiplier.
// A finished response waits in an output register; the next request is taken meanwhile.
// Synchronous active-high reset: registers to defaults, last commands to zero.
module lookahead_velocity_controller import lvc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_robot_x,
   input  logic signed [31:0] req_robot_y,
   input  logic signed [19:0] req_robot_heading,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [19:0] req_target_heading,
   input  logic               req_is_final,
   input  logic [23:0]        req_elapsed_time,
   input  logic               req_obstacle_seen,
   input  logic [23:0]        req_obstacle_range,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [23:0] rsp_fwd_velocity,
   output logic signed [23:0] rsp_side_velocity,
   output logic signed [23:0] rsp_turn_rate,
   // configuration write port
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [23:0]        csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // Register bank: speed caps, acceleration limits, stop range and arrival radius.
   lvc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Sequencer: idle, load, 17 CORDIC steps, 11 multiply steps, decide, limit.
   lvc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: frame rotation, bearing, nearness test, slowdown, rate limits.
   lvc_datapath u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .cfg                (cfg),
      .req_robot_x        (req_robot_x),
      .req_robot_y        (req_robot_y),
      .req_robot_heading  (req_robot_heading),
      .req_target_x       (req_target_x),
      .req_target_y       (req_target_y),
      .req_target_heading (req_target_heading),
      .req_is_final       (req_is_final),
      .req_elapsed_time   (req_elapsed_time),
      .req_obstacle_seen  (req_obstacle_seen),
      .req_obstacle_range (req_obstacle_range),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fwd_velocity   (rsp_fwd_velocity),
      .rsp_side_velocity  (rsp_side_velocity),
      .rsp_turn_rate      (rsp_turn_rate)
   );

endmodule

// ===== verif/lookahead_velocity_controller_test.sv =====
// Testbench for the lookahead velocity controller: random and directed ticks,
// a bit-exact velocity predictor and a command scoreboard. Depends on lvc_pkg.
`timescale 1ns / 100ps

module lookahead_velocity_controller_test import lvc_pkg::*; ();

   localparam int PERIOD_HI = 2;
   localparam int PERIOD_LO = 2;
   localparam int CYCLE_LIMIT = 400000;
   localparam longint PI_Q16 = 205887;
   localparam longint TWO_PI_Q16 = 411775;
   localparam longint HALF_PI_Q16 = 102944;

   typedef struct {
      logic signed [31:0] robot_x;
      logic signed [31:0] robot_y;
      logic signed [19:0] robot_heading;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [19:0] target_heading;
      logic               is_final;
      logic [23:0]        elapsed_time;
      logic               obstacle_seen;
      logic [23:0]        obstacle_range;
   } tick_type;

   typedef struct {
      logic signed [23:0] fwd;
      logic signed [23:0] side;
      logic signed [23:0] turn;
   } command_type;

   // predictor state and configuration copy
   longint cfg_max_fwd = 13107, cfg_max_turn = 19661;
   longint cfg_acc_fwd = 327680, cfg_acc_side = 65536, cfg_acc_turn = 327680;
   longint cfg_stop = 45875, cfg_arrive = 6554;
   longint prev_fwd, prev_side, prev_turn;

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint arctan_step(int i);
      longint tab[17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                          128, 64, 32, 16, 8, 4, 2, 1};
      return tab[i];
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint slew(longint v, longint last, longint acc, longint dt);
      longint d, ad, lim;
      d = v - last;
      ad = d < 0 ? -d : d;
      lim = acc * dt;
      if (ad * 65536 > lim) return v > last ? last + (lim >>> 16) : last - (lim >>> 16);
      return v;
   endfunction

   function automatic longint bearing(longint dy, longint dx);
      longint x, y, z, nx, ny;
      z = 0;
      if (dx == 0 && dy == 0) return 0;
      x = dx * 16777216;
      y = dy * 16777216;
      if (x < 0) begin
         z = (y >= 0) ? PI_Q16 : -PI_Q16;
         x = -x; y = -y;
      end
      for (int i = 0; i < 17; i++) begin
         if (y < 0) begin
            nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= arctan_step(i);
         end else begin
            nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += arctan_step(i);
         end
         x = nx; y = ny;
      end
      return z;
   endfunction

   function automatic command_type predict_command(tick_type t);
      longint rx, ry, rh, tx, ty, th, dx, dy, h, x, y, z, nx, ny, c, s;
      longint ex, ea, vx, vy, va, aex, aea;
      bit flip, near;
      command_type r;
      rx = t.robot_x; ry = t.robot_y; rh = t.robot_heading;
      tx = t.target_x; ty = t.target_y; th = t.target_heading;
      dx = tx - rx; dy = ty - ry;
      // heading sine/cosine by rotation in Q28
      h = rh; flip = 0;
      while (h > PI_Q16) h -= TWO_PI_Q16;
      while (h < -PI_Q16) h += TWO_PI_Q16;
      if (h > HALF_PI_Q16) begin h -= PI_Q16; flip = 1; end
      else if (h < -HALF_PI_Q16) begin h += PI_Q16; flip = 1; end
      x = 163008218; y = 0; z = h;
      for (int i = 0; i < 17; i++) begin
         if (z >= 0) begin
            nx = x - floor_shift(y, i); ny = y + floor_shift(x, i); z -= arctan_step(i);
         end else begin
            nx = x + floor_shift(y, i); ny = y - floor_shift(x, i); z += arctan_step(i);
         end
         x = nx; y = ny;
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
      ex = floor_shift(dx * c + dy * s + (longint'(1) << 27), 28);
      ea = bearing(dy, dx) - rh;
      if (ea < -PI_Q16) ea += TWO_PI_Q16;
      else if (ea > PI_Q16) ea -= TWO_PI_Q16;
      near = 0;
      if ((dx < 0 ? -dx : dx) < 16777216 && (dy < 0 ? -dy : dy) < 16777216)
         near = (dx * dx + dy * dy) < cfg_arrive * cfg_arrive;
      vx = cfg_max_fwd;
      if (near) vx = ex;
      if (vx > cfg_max_fwd) vx = cfg_max_fwd;
      vy = 0;
      va = ea;
      if (va > cfg_max_turn) va = cfg_max_turn;
      else if (va < -cfg_max_turn) va = -cfg_max_turn;
      aex = ex < 0 ? -ex : ex;
      aea = ea < 0 ? -ea : ea;
      if (aea > 98304) begin
         if (aex > 655) vx = 655;
      end else if (aea > 32768) begin
         if (aex > 1966) vx = 1966;
      end
      if (t.is_final && near) begin
         vx = 0; vy = 0; va = th - rh;
      end
      vx = slew(vx, prev_fwd, cfg_acc_fwd, t.elapsed_time);
      vy = slew(vy, prev_side, cfg_acc_side, t.elapsed_time);
      va = slew(va, prev_turn, cfg_acc_turn, t.elapsed_time);
      if (t.obstacle_seen && t.obstacle_range <= cfg_stop) begin
         vx = 0; vy = 0; va = 0;
      end
      prev_fwd = clamp24(vx); prev_side = clamp24(vy); prev_turn = clamp24(va);
      r.fwd = 24'(prev_fwd); r.side = 24'(prev_side); r.turn = 24'(prev_turn);
      return r;
   endfunction

   class command_scoreboard;
      command_type pending[$];
      int mismatches;

      function void note_request(command_type c);
         pending.insert(pending.size(), c);
      endfunction

      function void check_response(command_type got);
         command_type want;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response %0d %0d %0d",
                                           got.fwd, got.side, got.turn);
            return;
         end
         want = pending.pop_front();
         if (got.fwd !== want.fwd || got.side !== want.side || got.turn !== want.turn) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                        want.fwd, want.side, want.turn, got.fwd, got.side, got.turn);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_robot_x = 0, req_robot_y = 0, req_target_x = 0, req_target_y = 0;
   logic signed [19:0] req_robot_heading = 0, req_target_heading = 0;
   logic req_is_final = 0, req_obstacle_seen = 0;
   logic [23:0] req_elapsed_time = 0, req_obstacle_range = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [23:0] rsp_fwd_velocity, rsp_side_velocity, rsp_turn_rate;
   logic csr_write_en = 0;
   logic [2:0] csr_index = CSR_MAX_FWD;
   logic [23:0] csr_wdata = 0;

   command_scoreboard board = new();
   int cycle_count = 0;
   bit quiet_stretch = 0;   // no idling on either side while set
   int hold_off = 0;        // cycles the receiver still refuses responses

   lookahead_velocity_controller uut (.*);

   always begin
      #PERIOD_HI clock = 0;
      #PERIOD_LO clock = 1;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // response checking at the rising edge
   always @(posedge clock) begin
      command_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.fwd = rsp_fwd_velocity; got.side = rsp_side_velocity; got.turn = rsp_turn_rate;
         board.check_response(got);
      end
   end

   // receiver: random stall, or a long hold-off when requested
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_stall <= 1;
      end else
         rsp_stall <= !quiet_stretch && ($urandom_range(99) < 16);
   end

   task automatic write_reg(csr_idx_type idx, logic [23:0] value);
      @(negedge clock);
      csr_write_en <= 1; csr_index <= idx; csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 0;
      case (idx)
         CSR_MAX_FWD:  cfg_max_fwd = value[22:0];
         CSR_MAX_TURN: cfg_max_turn = value[22:0];
         CSR_ACC_FWD:  cfg_acc_fwd = value;
         CSR_ACC_SIDE: cfg_acc_side = value;
         CSR_ACC_TURN: cfg_acc_turn = value;
         CSR_STOP_RNG: cfg_stop = value;
         CSR_ARRIVE:   cfg_arrive = value;
         default:      ;
      endcase
   endtask

   // offer one request, hold it until accepted; leaves valid high
   task automatic send_tick(tick_type t);
      while (!quiet_stretch && $urandom_range(99) < 16) begin
         req_valid <= 0;
         @(negedge clock);
      end
      req_valid <= 1;
      req_robot_x <= t.robot_x; req_robot_y <= t.robot_y;
      req_robot_heading <= t.robot_heading;
      req_target_x <= t.target_x; req_target_y <= t.target_y;
      req_target_heading <= t.target_heading;
      req_is_final <= t.is_final; req_elapsed_time <= t.elapsed_time;
      req_obstacle_seen <= t.obstacle_seen; req_obstacle_range <= t.obstacle_range;
      do @(posedge clock); while (req_stall);
      board.note_request(predict_command(t));
      @(negedge clock);
   endtask

   task automatic drain;
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   function automatic tick_type random_tick(bit wide);
      tick_type t;
      int kind;
      kind = $urandom_range(99);
      t.robot_x = wide ? $urandom : $signed($urandom_range(40000)) - 20000 +
                  ($signed($urandom) >>> 12);
      t.robot_y = wide ? $urandom : $signed($urandom_range(40000)) - 20000 +
                  ($signed($urandom) >>> 12);
      t.robot_heading = (kind < 85) ? 20'($signed($urandom_range(411774)) - 205887)
                                    : 20'($urandom);
      if (kind < 40) begin
         // near the target to exercise arrival and the final turn
         t.target_x = t.robot_x + $signed($urandom_range(16000)) - 8000;
         t.target_y = t.robot_y + $signed($urandom_range(16000)) - 8000;
      end else if (kind < 50) begin
         t.target_x = t.robot_x; t.target_y = t.robot_y;
      end else begin
         t.target_x = wide ? $urandom : t.robot_x + ($signed($urandom) >>> $urandom_range(20, 4));
         t.target_y = wide ? $urandom : t.robot_y + ($signed($urandom) >>> $urandom_range(20, 4));
      end
      t.target_heading = 20'($urandom);
      t.is_final = 1'($urandom_range(1));
      t.elapsed_time = ($urandom_range(9) == 0) ? 24'($urandom) :
                       ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(2000));
      t.obstacle_seen = 1'($urandom_range(1));
      t.obstacle_range = ($urandom_range(1)) ? 24'($urandom) : 24'($urandom_range(90000));
      return t;
   endfunction

   initial begin
      tick_type t;
      int extremes[4];
      extremes = '{32'sh7FFFFFFF, 32'sh80000000, 0, -1};
      prev_fwd = 0; prev_side = 0; prev_turn = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: field extremes and special cases under reset settings
      for (int i = 0; i < 4; i++) begin
         t.robot_x = extremes[i]; t.robot_y = extremes[3 - i];
         t.target_x = extremes[3 - i]; t.target_y = extremes[i];
         t.robot_heading = i[0] ? 20'sh7FFFF : 20'sh80000;
         t.target_heading = i[1] ? 20'sh80000 : 20'sh7FFFF;
         t.is_final = i[0]; t.elapsed_time = i[1] ? 24'hFFFFFF : 24'd0;
         t.obstacle_seen = i[0]; t.obstacle_range = i[1] ? 24'hFFFFFF : 24'd0;
         send_tick(t);
      end
      // zero offset, final arrival, zero dt, obstacle at exactly stop range
      t = '{default: 0};
      t.elapsed_time = 24'd655; send_tick(t);
      t.is_final = 1'b1; t.target_heading = 20'sh7FFFF; t.robot_heading = 20'sh80000;
      t.elapsed_time = 24'hFFFFFF; send_tick(t);
      t.elapsed_time = 24'd0; t.target_x = 100; send_tick(t);
      t.obstacle_seen = 1'b1; t.obstacle_range = 24'd45875; t.elapsed_time = 24'd1000;
      send_tick(t);
      t.obstacle_range = 24'd45876; send_tick(t);
      t = '{default: 0}; t.target_x = -1000; t.elapsed_time = 24'd2000; send_tick(t);
      t.target_x = 0; t.target_y = 3000; t.robot_heading = 20'sh40000; send_tick(t);
      drain();

      // random phases across register settings
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_reg(CSR_MAX_FWD, 24'h7FFFFF); write_reg(CSR_MAX_TURN, 24'h7FFFFF);
               write_reg(CSR_ACC_FWD, 24'hFFFFFF); write_reg(CSR_ACC_SIDE, 24'hFFFFFF);
               write_reg(CSR_ACC_TURN, 24'hFFFFFF); write_reg(CSR_STOP_RNG, 24'hFFFFFF);
               write_reg(CSR_ARRIVE, 24'hFFFFFF);
            end
            1: begin
               write_reg(CSR_MAX_FWD, 24'd0); write_reg(CSR_MAX_TURN, 24'd0);
               write_reg(CSR_ACC_FWD, 24'd0); write_reg(CSR_ACC_SIDE, 24'd0);
               write_reg(CSR_ACC_TURN, 24'd0); write_reg(CSR_STOP_RNG, 24'd0);
               write_reg(CSR_ARRIVE, 24'd0);
            end
            default: begin
               write_reg(CSR_MAX_FWD, 24'($urandom_range(30000)));
               write_reg(CSR_MAX_TURN, 24'($urandom_range(200000)));
               write_reg(CSR_ACC_FWD, 24'($urandom_range(700000)));
               write_reg(CSR_ACC_SIDE, 24'($urandom));
               write_reg(CSR_ACC_TURN, 24'($urandom_range(700000)));
               write_reg(CSR_STOP_RNG, 24'($urandom_range(90000)));
               write_reg(CSR_ARRIVE, 24'($urandom_range(12000)));
            end
         endcase
         for (int n = 0; n < 240; n++) begin
            quiet_stretch = (phase == 3 && n >= 40 && n < 120);
            // stop draining responses for a while; requests keep coming
            if (phase == 4 && n == 50) hold_off = 600;
            send_tick(random_tick($urandom_range(9) == 0));
         end
         quiet_stretch = 0;
         drain();
      end

      if (board.mismatches == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
